/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PTAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PTAT_ASSERT_IMP(label, ante, cons, msg) \
  `PTAT_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* hdl/ptat_pkg.sv */
// Types, constants and codes of the page table address translation block.
package ptat_pkg;

  // Sizes of the page table and the address spaces
  localparam int PAGE_SIZE      = 128;
  localparam int NUM_PHYS_PAGES = 128;
  localparam int MAX_PAGES      = 64;

  // Fixed field widths
  localparam int VA_W       = 32;
  localparam int PA_W       = 14;
  localparam int FRAME_W    = 8;
  localparam int ENTRY_IDX_W = 6;
  localparam int CFG_W      = 7;
  localparam int CMP_W      = 9;

  // Derived widths
  localparam int OFFSET_W = $clog2(PAGE_SIZE);
  localparam int VPN_W    = VA_W - OFFSET_W;
  localparam int IDX_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ADDR = 2'd1,
    ST_RO   = 2'd2,
    ST_BUS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_SKIP     = 2'd1,
    KIND_ADDR_ERR = 2'd2,
    KIND_LOOKUP   = 2'd3
  } kind_e;

  // One page table entry as held in the table memory
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               read_only;
    logic               used;
    logic               dirty;
  } pte_t;

  localparam int PTE_W = $bits(pte_t);

  // One classified transaction passed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [IDX_W-1:0]    idx;
    logic [OFFSET_W-1:0] offset;
    logic                is_write;
    logic [FRAME_W-1:0]  frame;
    logic                read_only;
  } cmd_t;

endpackage

/* hdl/ptat_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ptat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ptat_front.sv */
// Front end: holds the page count register and classifies accepted transactions.
module ptat_front import ptat_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   accept_i,
  input  logic                   op_i,
  input  logic [VA_W-1:0]        virtual_address_i,
  input  logic                   is_write_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [FRAME_W-1:0]     entry_frame_i,
  input  logic                   entry_read_only_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  logic [CFG_W-1:0] page_count_q;
  logic [VPN_W-1:0] vpn;
  logic [CMP_W-1:0] entry_index_ext;
  logic             addr_err;
  logic             index_beyond;

  // Hold the page count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= '0;
    end else if (cfg_valid_i) begin
      page_count_q <= cfg_data_i;
    end
  end

  // Split the address and check the page number against the mapped range
  assign vpn             = virtual_address_i[VA_W-1:OFFSET_W];
  assign addr_err        = (vpn >= VPN_W'(page_count_q)) || (vpn >= VPN_W'(MAX_PAGES));
  assign entry_index_ext = CMP_W'(entry_index_i);
  assign index_beyond    = entry_index_ext >= CMP_W'(MAX_PAGES);

  // Build the classified transaction
  always_comb begin
    cmd_o.offset    = virtual_address_i[OFFSET_W-1:0];
    cmd_o.is_write  = is_write_i;
    cmd_o.frame     = entry_frame_i;
    cmd_o.read_only = entry_read_only_i;
    if (!op_i) begin
      cmd_o.idx  = entry_index_ext[IDX_W-1:0];
      cmd_o.kind = index_beyond ? KIND_SKIP : KIND_WRITE;
    end else begin
      cmd_o.idx  = vpn[IDX_W-1:0];
      cmd_o.kind = addr_err ? KIND_ADDR_ERR : KIND_LOOKUP;
    end
  end

  assign push_o = accept_i;

endmodule

/* hdl/ptat_queue.sv */
// Short FIFO of classified transactions between front and back.
module ptat_queue import ptat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed transactions
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/ptat_back.sv */
// Back end: owns the page table memory, runs writes and lookups, drives results.
module ptat_back import ptat_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  output logic            done_o,
  output status_e         status_o,
  output logic [PA_W-1:0] physical_address_o
);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_CHECK = 2'b10
  } back_state_e;

  back_state_e         state_q, state_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [PA_W-1:0]     pa_q, pa_d;
  logic [IDX_W-1:0]    pend_idx_q;
  logic [OFFSET_W-1:0] pend_offset_q;
  logic                pend_write_q;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  pte_t                ram_wdata;
  logic                ram_re;
  pte_t                ram_rdata;
  logic [PTE_W-1:0]    ram_rdata_raw;

  logic [FRAME_W+OFFSET_W+PA_W-1:0] pa_wide;

  ptat_ram #(
    .WIDTH (PTE_W),
    .DEPTH (MAX_PAGES),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.idx),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pte_t'(ram_rdata_raw);
  assign pa_wide   = {{PA_W{1'b0}}, ram_rdata.frame, pend_offset_q};

  // Sequence one transaction at a time; lookups go on to the check state
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    status_d  = ST_OK;
    pa_d      = '0;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cmd_i.idx;
    ram_wdata = '{frame: cmd_i.frame, read_only: cmd_i.read_only, used: 1'b0, dirty: 1'b0};
    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_WRITE: begin
              ram_we = 1'b1;
              done_d = 1'b1;
            end
            KIND_ADDR_ERR: begin
              done_d   = 1'b1;
              status_d = ST_ADDR;
            end
            KIND_LOOKUP: begin
              ram_re  = 1'b1;
              state_d = BK_CHECK;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      BK_CHECK: begin
        done_d  = 1'b1;
        state_d = BK_IDLE;
        if (pend_write_q && ram_rdata.read_only) begin
          status_d = ST_RO;
        end else if (CMP_W'(ram_rdata.frame) >= CMP_W'(NUM_PHYS_PAGES)) begin
          status_d = ST_BUS;
        end else begin
          // Mark the page used, and dirty on a write access
          pa_d      = pa_wide[PA_W-1:0];
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q;
          ram_wdata = '{frame: ram_rdata.frame, read_only: ram_rdata.read_only,
                        used: 1'b1, dirty: ram_rdata.dirty | pend_write_q};
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Hold result payload and the pending lookup
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pa_q     <= pa_d;
    if (ram_re) begin
      pend_idx_q    <= cmd_i.idx;
      pend_offset_q <= cmd_i.offset;
      pend_write_q  <= cmd_i.is_write;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign physical_address_o = pa_q;

endmodule

/* hdl/page_table_address_translate.sv */
// Top level of the single-level page table with address translation.
//
// A transaction is taken when start is high and busy is low; each gives
// exactly one result, shown for one cycle with done_o high, in order. The
// front classifies a transaction in the cycle it is taken and places it in
// a two-entry queue; busy is high while that queue is full. The back ends
// a table write, an ignored write or an address error in its idle state
// and takes a table lookup on to its check state, bound by the registered
// read of the single table memory followed by the check and write-back of
// the use and dirty marks. A transaction passes through the queue and the
// registered result of the back; a lookup also passes through the table read
// and the check state. Writes are taken one per cycle while busy is low,
// and the back takes no new transaction while it checks a lookup. The page
// count register is written at any cycle in which cfg_valid_i is high
// (cfg_ready_o is always high). Table entries hold no defined value after
// reset and must be written before they are translated.
module page_table_address_translate import ptat_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op_i,
  input  logic [VA_W-1:0]        virtual_address_i,
  input  logic                   is_write_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [FRAME_W-1:0]     entry_frame_i,
  input  logic                   entry_read_only_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [PA_W-1:0]        physical_address_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  logic    queue_full;
  logic    queue_valid;
  cmd_t    queue_cmd;
  logic    pop;
  status_e status;

  assign cfg_ready_o = 1'b1;
  assign busy        = queue_full;
  assign accept      = start && !queue_full;

  ptat_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .accept_i          (accept),
    .op_i              (op_i),
    .virtual_address_i (virtual_address_i),
    .is_write_i        (is_write_i),
    .entry_index_i     (entry_index_i),
    .entry_frame_i     (entry_frame_i),
    .entry_read_only_i (entry_read_only_i),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  ptat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  ptat_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (queue_valid),
    .cmd_i              (queue_cmd),
    .pop_o              (pop),
    .done_o             (done_o),
    .status_o           (status),
    .physical_address_o (physical_address_o)
  );

  assign status_o = status;

endmodule

/* hdl/ptat_checker.sv */
// Port-level checker for the page table address translation block, with its bind.
`include "assert_macros.svh"

module ptat_checker import ptat_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [1:0]      status_o,
  input logic [PA_W-1:0] physical_address_o
);

  logic       accept;
  logic [2:0] outstanding_q;

  assign accept = start && !busy;

  // Track transactions taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (accept && !done_o) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (done_o && !accept) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  `PTAT_ASSERT_IMP(a_no_spurious_result, done_o, outstanding_q != '0, "result without transaction")
  `PTAT_ASSERT_IMP(a_busy_only_when_backed_up, busy, outstanding_q >= 3'd2, "busy with queue not full")
  `PTAT_ASSERT_IMP(a_error_clears_address, done_o && (status_o != ST_OK), physical_address_o == '0, "error result carries an address")

endmodule

bind page_table_address_translate ptat_checker u_checker (.*);
